// File: hw/rtl/acht_pkg.sv
// Shared types and constants for the associative cache hit tracker.
`timescale 1ns / 1ps

package acht_pkg;

  localparam int ENTRIES_DEF   = 256;
  localparam int ADDR_BITS_DEF = 32;

  localparam int ADDR_W  = 32;   // address port width
  localparam int SLOT_W  = 8;    // reported slot index width
  localparam int CNT_W   = 32;   // statistics counter width
  localparam int FILL_W  = 9;    // fill level, 0..256
  localparam int LFSR_W  = 16;
  localparam int SIZE_W  = 4;
  localparam int STEP_W  = 3;    // remainder unit step counter

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  localparam logic [SIZE_W-1:0] SIZE_LOG2_RST = 4'd8;
  localparam logic [SIZE_W-1:0] SIZE_LOG2_MAX = 4'd8;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOD,
    ST_WRITE,
    ST_OUT
  } acht_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;          // latch word, bump read/write counter
    logic scan;          // walk the tag store
    logic take_hit;      // record a hit at the compared entry
    logic miss_fill;     // miss into next free entry
    logic miss_replace;  // miss, step LFSR and start victim reduction
    logic mod_step;      // one step of the victim remainder
    logic write;         // store address into the chosen slot
  } acht_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit_found;
    logic scan_done;
    logic has_free;
    logic mod_last;
  } acht_sts_t;

endpackage

// File: hw/rtl/acht_ctrl.sv
// Sequencing state machine for the associative cache hit tracker.
`timescale 1ns / 1ps

module acht_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  acht_pkg::acht_sts_t sts,
  output acht_pkg::acht_cmd_t cmd,
  output logic              busy,
  output logic              out_valid
);
  import acht_pkg::*;

  acht_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit_found) begin
          cmd.take_hit = 1'b1;
          state_nxt    = ST_OUT;
        end else if (sts.scan_done) begin
          if (sts.has_free) begin
            cmd.miss_fill = 1'b1;
            state_nxt     = ST_WRITE;
          end else begin
            cmd.miss_replace = 1'b1;
            state_nxt        = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/acht_datapath.sv
// Tag store, scan compare, victim selection and counters of the hit tracker.
`timescale 1ns / 1ps

module acht_datapath #(
  parameter int ENTRIES   = acht_pkg::ENTRIES_DEF,
  parameter int ADDR_BITS = acht_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  acht_pkg::acht_cmd_t           cmd,
  output acht_pkg::acht_sts_t           sts,
  input  logic                          in_command,
  input  logic [acht_pkg::ADDR_W-1:0]   in_address,
  input  logic                          cfg_we,
  input  logic [acht_pkg::SIZE_W-1:0]   cfg_data,
  output logic                          out_hit,
  output logic [acht_pkg::SLOT_W-1:0]   out_slot,
  output logic                          out_replaced,
  output logic [acht_pkg::CNT_W-1:0]    out_hit_count,
  output logic [acht_pkg::CNT_W-1:0]    out_miss_count,
  output logic [acht_pkg::CNT_W-1:0]    out_read_count,
  output logic [acht_pkg::CNT_W-1:0]    out_write_count
);
  import acht_pkg::*;

  localparam int TAG_W = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // the size register never selects more than 256 entries
  localparam logic [FILL_W-1:0] ENT_CAP = (ENTRIES > 256) ? 9'd256 : FILL_W'(ENTRIES);

  logic [TAG_W-1:0] mem [ENTRIES];

  logic [SIZE_W-1:0] size_log2_r;
  logic [FILL_W-1:0] fill_r;
  logic [LFSR_W-1:0] lfsr_r;
  logic [CNT_W-1:0]  hits_r, misses_r, reads_r, writes_r;

  logic [TAG_W-1:0]  addr_r;
  logic [FILL_W-1:0] lim_r;
  logic [FILL_W-1:0] scan_r;
  logic              rd_vld_r;
  logic [SLOT_W-1:0] rd_idx_r;
  logic [TAG_W-1:0]  rdata_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] rem_r;
  logic [STEP_W-1:0] step_r;
  logic              hit_r;
  logic              replaced_r;

  logic [SIZE_W-1:0] lg;
  logic [FILL_W-1:0] pow;
  logic [FILL_W-1:0] active;
  logic [SLOT_W-1:0] pmask;
  logic              issue;
  logic [LFSR_W-1:0] lfsr_nxt;
  logic [15:0]       sub_val;
  logic [SLOT_W-1:0] rem_nxt;

  always_comb begin
    lg     = (size_log2_r > SIZE_LOG2_MAX) ? SIZE_LOG2_MAX : size_log2_r;
    pow    = FILL_W'(1) << lg;
    active = (pow > ENT_CAP) ? ENT_CAP : pow;
    pmask  = SLOT_W'(pow - FILL_W'(1));
    issue  = cmd.scan && (scan_r < lim_r);

    if (lfsr_r[0]) begin
      lfsr_nxt = (lfsr_r >> 1) ^ LFSR_TAPS;
    end else begin
      lfsr_nxt = lfsr_r >> 1;
    end

    // restoring remainder: the value is below 256, so eight shifted
    // subtractions of the entry count reduce it fully
    sub_val = 16'(active) << step_r;
    if (16'(rem_r) >= sub_val) begin
      rem_nxt = rem_r - sub_val[SLOT_W-1:0];
    end else begin
      rem_nxt = rem_r;
    end

    sts.hit_found = rd_vld_r && (rdata_r == addr_r);
    sts.scan_done = !rd_vld_r && (scan_r >= lim_r);
    sts.has_free  = fill_r < active;
    sts.mod_last  = (step_r == '0);
  end

  // tag store ports
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[IDX_W'(slot_r)] <= addr_r;
    end
    if (issue) begin
      rdata_r <= mem[IDX_W'(scan_r)];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_log2_r <= SIZE_LOG2_RST;
      fill_r      <= '0;
      lfsr_r      <= LFSR_SEED;
      hits_r      <= '0;
      misses_r    <= '0;
      reads_r     <= '0;
      writes_r    <= '0;
      rd_vld_r    <= 1'b0;
      scan_r      <= '0;
    end else begin
      rd_vld_r <= issue;
      if (cfg_we) begin
        size_log2_r <= cfg_data;
      end
      if (cmd.load) begin
        scan_r <= '0;
        if (in_command == CMD_WRITE) begin
          if (writes_r != '1) writes_r <= writes_r + CNT_W'(1);
        end else begin
          if (reads_r != '1) reads_r <= reads_r + CNT_W'(1);
        end
      end else if (issue) begin
        scan_r <= scan_r + FILL_W'(1);
      end
      if (cmd.take_hit && hits_r != '1) begin
        hits_r <= hits_r + CNT_W'(1);
      end
      if ((cmd.miss_fill || cmd.miss_replace) && misses_r != '1) begin
        misses_r <= misses_r + CNT_W'(1);
      end
      if (cmd.miss_fill) begin
        fill_r <= fill_r + FILL_W'(1);
      end
      if (cmd.miss_replace) begin
        lfsr_r <= lfsr_nxt;
      end
    end
  end

  // per-word payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r     <= in_address[TAG_W-1:0];
      lim_r      <= (fill_r < active) ? fill_r : active;
      hit_r      <= 1'b0;
      replaced_r <= 1'b0;
    end
    if (issue) begin
      rd_idx_r <= scan_r[SLOT_W-1:0];
    end
    if (cmd.take_hit) begin
      hit_r  <= 1'b1;
      slot_r <= rd_idx_r;
    end
    if (cmd.miss_fill) begin
      slot_r <= fill_r[SLOT_W-1:0];
    end
    if (cmd.miss_replace) begin
      replaced_r <= 1'b1;
      rem_r      <= lfsr_nxt[SLOT_W-1:0] & pmask;
      step_r     <= STEP_W'(SLOT_W - 1);
    end
    if (cmd.mod_step) begin
      rem_r  <= rem_nxt;
      step_r <= step_r - STEP_W'(1);
      if (step_r == '0) begin
        slot_r <= rem_nxt;
      end
    end
  end

  assign out_hit         = hit_r;
  assign out_slot        = slot_r;
  assign out_replaced    = replaced_r;
  assign out_hit_count   = hits_r;
  assign out_miss_count  = misses_r;
  assign out_read_count  = reads_r;
  assign out_write_count = writes_r;

endmodule

// File: hw/rtl/assoc_cache_hit_tracker_core.sv
// Fully associative cache hit tracker with LFSR victim replacement, top level.
`timescale 1ns / 1ps

// Usage: raise start with in_command/in_address while busy is low; the word
// is taken on that edge and busy stays high until the result has been shown.
// The result is on the out_ ports for exactly one cycle with out_valid high,
// and the receiver cannot stall it, so it must capture it then. The tag store
// has one read port and is walked one entry per cycle, and on a replacing
// miss the victim index is reduced modulo the entry count over eight
// compare-subtract steps. The size register is written through cfg_;
// cfg_ready is low while busy or start is high, so a size write never lands
// together with an access.
module assoc_cache_hit_tracker_core #(
  parameter int ENTRIES   = acht_pkg::ENTRIES_DEF,
  parameter int ADDR_BITS = acht_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_command,
  input  logic [acht_pkg::ADDR_W-1:0]   in_address,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [acht_pkg::SLOT_W-1:0]   out_slot,
  output logic                          out_replaced,
  output logic [acht_pkg::CNT_W-1:0]    out_hit_count,
  output logic [acht_pkg::CNT_W-1:0]    out_miss_count,
  output logic [acht_pkg::CNT_W-1:0]    out_read_count,
  output logic [acht_pkg::CNT_W-1:0]    out_write_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [acht_pkg::SIZE_W-1:0]   cfg_data
);
  import acht_pkg::*;

  acht_cmd_t cmd;
  acht_sts_t sts;
  logic      cfg_we;

  assign cfg_ready = ~busy & ~start;
  assign cfg_we    = cfg_valid & cfg_ready;

  acht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  acht_datapath #(
    .ENTRIES   (ENTRIES),
    .ADDR_BITS (ADDR_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_command      (in_command),
    .in_address      (in_address),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .out_hit         (out_hit),
    .out_slot        (out_slot),
    .out_replaced    (out_replaced),
    .out_hit_count   (out_hit_count),
    .out_miss_count  (out_miss_count),
    .out_read_count  (out_read_count),
    .out_write_count (out_write_count)
  );

endmodule

// File: verif/assoc_cache_hit_tracker_core_tb.sv
// Self-checking testbench for the associative cache hit tracker core.
`timescale 1ns / 1ps

module assoc_cache_hit_tracker_core_tb;
  import acht_pkg::*;

  localparam int NUM_ENTRIES = ENTRIES_DEF;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 110;
  localparam int POOL_DEPTH  = 32;

  typedef struct {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              replaced;
    logic [CNT_W-1:0]  hit_count;
    logic [CNT_W-1:0]  miss_count;
    logic [CNT_W-1:0]  read_count;
    logic [CNT_W-1:0]  write_count;
  } lookup_t;

  // Tracks cache contents and counters, predicts each lookup word.
  class cache_lookup_checker;
    logic [ADDR_W-1:0] tags [NUM_ENTRIES];
    int unsigned       fill;
    logic [LFSR_W-1:0] lfsr;
    logic [CNT_W-1:0]  hits, misses, reads, writes;
    logic [SIZE_W-1:0] size_log2;
    lookup_t           lookup_q[$];
    int unsigned       errors, checked, accesses, replacements;

    function new();
      fill = 0;
      lfsr = LFSR_SEED;
      hits = '0;
      misses = '0;
      reads = '0;
      writes = '0;
      size_log2 = SIZE_LOG2_RST;
      errors = 0;
      checked = 0;
      accesses = 0;
      replacements = 0;
    endfunction

    function int unsigned active();
      int unsigned lg, n;
      lg = (size_log2 > SIZE_LOG2_MAX) ? SIZE_LOG2_MAX : size_log2;
      n = 1 << lg;
      return (n > NUM_ENTRIES) ? NUM_ENTRIES : n;
    endfunction

    function logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function void set_size(logic [SIZE_W-1:0] v);
      size_log2 = v;
    endfunction

    function int unsigned pending();
      return lookup_q.size();
    endfunction

    function void note_access(logic cmd, logic [ADDR_W-1:0] addr);
      lookup_t     e;
      int unsigned n, lim, i, lg, pmask, victim;
      e.hit = 1'b0;
      e.slot = '0;
      e.replaced = 1'b0;
      n = active();
      lim = (fill < n) ? fill : n;
      if (cmd == CMD_WRITE) writes = sat_inc(writes);
      else reads = sat_inc(reads);
      // lowest matching entry wins; only valid entries below the size are searched
      for (i = 0; i < lim; i++) begin
        if (!e.hit && tags[i] == addr) begin
          e.hit = 1'b1;
          e.slot = SLOT_W'(i);
        end
      end
      if (e.hit) begin
        hits = sat_inc(hits);
      end else begin
        misses = sat_inc(misses);
        if (fill < n) begin
          e.slot = SLOT_W'(fill);
          tags[fill] = addr;
          fill++;
        end else begin
          lg = (size_log2 > SIZE_LOG2_MAX) ? SIZE_LOG2_MAX : size_log2;
          pmask = (1 << lg) - 1;
          if (lfsr[0]) lfsr = (lfsr >> 1) ^ LFSR_TAPS;
          else lfsr = lfsr >> 1;
          victim = (int'(lfsr) & pmask) % n;
          e.slot = SLOT_W'(victim);
          tags[victim] = addr;
          e.replaced = 1'b1;
          replacements++;
        end
      end
      e.hit_count = hits;
      e.miss_count = misses;
      e.read_count = reads;
      e.write_count = writes;
      lookup_q.push_back(e);
      accesses++;
    endfunction

    function void check_field(string name, logic [CNT_W-1:0] exp, logic [CNT_W-1:0] act);
      if (exp !== act) begin
        $error("%s: expected %0h, got %0h", name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(lookup_t got);
      lookup_t e;
      if (lookup_q.size() == 0) begin
        $error("lookup word with no access outstanding");
        errors++;
        return;
      end
      e = lookup_q.pop_front();
      check_field("hit", CNT_W'(e.hit), CNT_W'(got.hit));
      check_field("slot", CNT_W'(e.slot), CNT_W'(got.slot));
      check_field("replaced", CNT_W'(e.replaced), CNT_W'(got.replaced));
      check_field("hit_count", e.hit_count, got.hit_count);
      check_field("miss_count", e.miss_count, got.miss_count);
      check_field("read_count", e.read_count, got.read_count);
      check_field("write_count", e.write_count, got.write_count);
      checked++;
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_command;
  logic [ADDR_W-1:0] in_address;
  logic              out_valid;
  logic              out_hit;
  logic [SLOT_W-1:0] out_slot;
  logic              out_replaced;
  logic [CNT_W-1:0]  out_hit_count;
  logic [CNT_W-1:0]  out_miss_count;
  logic [CNT_W-1:0]  out_read_count;
  logic [CNT_W-1:0]  out_write_count;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_data;

  cache_lookup_checker sb = new();
  logic [ADDR_W-1:0]   recent_addr[$];
  int unsigned         size_writes;

  assoc_cache_hit_tracker_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_address     (in_address),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_slot       (out_slot),
    .out_replaced   (out_replaced),
    .out_hit_count  (out_hit_count),
    .out_miss_count (out_miss_count),
    .out_read_count (out_read_count),
    .out_write_count(out_write_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // result strobe cannot be held off: sample every cycle
  always @(posedge clk) begin
    lookup_t got;
    if (rst_n && out_valid) begin
      got.hit = out_hit;
      got.slot = out_slot;
      got.replaced = out_replaced;
      got.hit_count = out_hit_count;
      got.miss_count = out_miss_count;
      got.read_count = out_read_count;
      got.write_count = out_write_count;
      sb.check_result(got);
    end
  end

  // Called at a rising edge; returns at the edge the word is taken, start still high.
  // Each cycle the sender holds start low with the given percentage.
  task automatic drive_access(input logic cmd, input logic [ADDR_W-1:0] addr,
                              input int unsigned idle_pct = 0);
    logic offered;
    in_command <= cmd;
    in_address <= addr;
    do begin
      offered = ($urandom_range(99) >= idle_pct);
      start <= offered;
      @(posedge clk);
    end while (!(offered && !busy));
    sb.note_access(cmd, addr);
  endtask

  // hold off until every lookup word is back and the core is idle
  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_size(v);
    size_writes++;
  endtask

  // mostly reuse recent addresses so hits happen; some near misses and fresh ones
  function automatic logic [ADDR_W-1:0] next_address();
    logic [ADDR_W-1:0] a;
    int unsigned       r;
    r = $urandom_range(99);
    if (recent_addr.size() != 0 && r < 55)
      a = recent_addr[$urandom_range(recent_addr.size() - 1)];
    else if (recent_addr.size() != 0 && r < 65)
      a = recent_addr[$urandom_range(recent_addr.size() - 1)] ^ (32'd1 << $urandom_range(31));
    else
      a = $urandom();
    recent_addr.push_back(a);
    if (recent_addr.size() > POOL_DEPTH) void'(recent_addr.pop_front());
    return a;
  endfunction

  initial begin
    logic [SIZE_W-1:0] phase_size [NUM_PHASES];
    int unsigned       p, k, idle_pct;
    phase_size = '{4'd3, 4'd0, 4'd5, 4'd1, 4'd9, 4'd2, 4'd4, 4'd15, 4'd6, 4'd8, 4'd7, 4'd8};
    size_writes = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_command <= CMD_READ;
    in_address <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // fills, hits on both address extremes, both commands
    drive_access(CMD_READ, 32'h0000_0000);
    drive_access(CMD_WRITE, 32'hFFFF_FFFF);
    drive_access(CMD_READ, 32'h0000_0000);
    drive_access(CMD_WRITE, 32'hFFFF_FFFF);
    drive_access(CMD_READ, 32'h8000_0000);
    drive_access(CMD_WRITE, 32'h0000_0001);
    drive_access(CMD_READ, 32'h0000_0001);
    // single entry: cache is over-full, every miss replaces entry 0
    drain_results();
    write_size(4'd0);
    drive_access(CMD_READ, 32'hFFFF_FFFF);
    drive_access(CMD_READ, 32'hFFFF_FFFF);
    // size above range acts as the full store; duplicate tags hit lowest entry
    drain_results();
    write_size(4'd15);
    drive_access(CMD_WRITE, 32'hFFFF_FFFF);
    drive_access(CMD_READ, 32'h1234_5678);
    // shrink below fill level: replacements, and tag above the size is not found
    drain_results();
    write_size(4'd2);
    drive_access(CMD_WRITE, 32'hDEAD_BEEF);
    drive_access(CMD_READ, 32'h5555_AAAA);
    drive_access(CMD_WRITE, 32'hAAAA_5555);
    drive_access(CMD_READ, 32'h0F0F_F0F0);
    drive_access(CMD_READ, 32'h1234_5678);

    for (p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_size(phase_size[p]);
      idle_pct = (p < 4) ? 38 : (p < 8) ? 68 : 0;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        drive_access(1'($urandom_range(1)), next_address(), idle_pct);
      end
    end

    drain_results();
    repeat (300) @(posedge clk);
    $display("checked %0d lookups of %0d accesses: %0d hits, %0d misses, %0d replacing",
             sb.checked, sb.accesses, sb.hits, sb.misses, sb.replacements);
    $display("%0d size writes, sizes from one entry up to the full store and beyond",
             size_writes);
    if (sb.errors == 0)
      $display("assoc_cache_hit_tracker_core_tb: done, clean");
    else
      $display("assoc_cache_hit_tracker_core_tb: done, errors");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("assoc_cache_hit_tracker_core_tb: done, errors");
    $finish;
  end

endmodule
